/* hw/rtl/i2cm_pkg.sv */
// Shared types and register map for the I2C transaction master.
package i2cm_pkg;

    // Register map of the configuration port.
    localparam int unsigned ApbAddrW   = 3;
    localparam int unsigned ApbDataW   = 32;
    localparam int unsigned CfgRegW    = 8;
    localparam logic [CfgRegW-1:0] TicksPerUsReset   = 8'd1;
    localparam logic [CfgRegW-1:0] AckWaitLimitReset = 8'd250;

    // Register index as carried by address bit 2.
    typedef enum logic {
        CFG_TICKS_PER_US   = 1'b0,
        CFG_ACK_WAIT_LIMIT = 1'b1
    } cfg_index_t;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic [CfgRegW-1:0] ticks_per_us;
        logic [CfgRegW-1:0] ack_wait_limit;
    } cfg_t;

    // One input beat: a timebase tick.
    typedef struct packed {
        logic       start_req;
        logic [1:0] mode;
        logic [7:0] slave_addr;
        logic [7:0] sub_addr;
        logic [7:0] byte_count;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       tx_request;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       ack_error;
        logic       busy_res;
    } res_item_t;

endpackage

/* hw/rtl/i2c_master_transaction.sv */
// Top level: input and result registers, configuration port and the bus sequencer.
// A tick is held in the input register, then in the result register, whose beat shows on m_valid.
// One tick per clock cycle while m_ready is high; the sequencer updates its state once per tick taken.
// A stalled result register holds one beat while the input register takes the next.
// Reset is synchronous on aresetn low: the bus goes idle and both registers empty.
// Reset sets ticks_per_us to 1 and ack_wait_limit to 250.
module i2c_master_transaction (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::ApbAddrW-1:0]  paddr,
    input  logic [i2cm_pkg::ApbDataW-1:0]  pwdata,
    output logic [i2cm_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    // Tick channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_req,
    input  logic [1:0]                     s_mode,
    input  logic [7:0]                     s_slave_addr,
    input  logic [7:0]                     s_sub_addr,
    input  logic [7:0]                     s_byte_count,
    input  logic                           s_tx_valid,
    input  logic [7:0]                     s_tx_byte,
    input  logic                           s_sda_in,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_scl_out,
    output logic                           m_sda_out,
    output logic                           m_sda_drive,
    output logic                           m_tx_request,
    output logic                           m_rx_valid,
    output logic [7:0]                     m_rx_byte,
    output logic                           m_done_res,
    output logic                           m_ack_error,
    output logic                           m_busy_res
);
    import i2cm_pkg::*;

    cfg_t       cfg_reg;
    cfg_index_t cfg_index;
    logic       cfg_write;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    res_item_t  out_item_reg;
    res_item_t  seq_result;
    logic       advance;

    // Configuration registers; the register is chosen by address bit 2.
    assign pready    = 1'b1;
    assign cfg_index = cfg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_us   <= TicksPerUsReset;
            cfg_reg.ack_wait_limit <= AckWaitLimitReset;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_TICKS_PER_US:   cfg_reg.ticks_per_us   <= pwdata[CfgRegW-1:0];
                CFG_ACK_WAIT_LIMIT: cfg_reg.ack_wait_limit <= pwdata[CfgRegW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            CFG_TICKS_PER_US:   prdata = {{(ApbDataW-CfgRegW){1'b0}}, cfg_reg.ticks_per_us};
            CFG_ACK_WAIT_LIMIT: prdata = {{(ApbDataW-CfgRegW){1'b0}}, cfg_reg.ack_wait_limit};
            default:            prdata = '0;
        endcase
    end

    // A held tick moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{start_req:  s_start_req,
                             mode:       s_mode,
                             slave_addr: s_slave_addr,
                             sub_addr:   s_sub_addr,
                             byte_count: s_byte_count,
                             tx_valid:   s_tx_valid,
                             tx_byte:    s_tx_byte,
                             sda_in:     s_sda_in};
        end
    end

    i2cm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (seq_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= seq_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_out    = out_item_reg.scl_out;
    assign m_sda_out    = out_item_reg.sda_out;
    assign m_sda_drive  = out_item_reg.sda_drive;
    assign m_tx_request = out_item_reg.tx_request;
    assign m_rx_valid   = out_item_reg.rx_valid;
    assign m_rx_byte    = out_item_reg.rx_byte;
    assign m_done_res   = out_item_reg.done_res;
    assign m_ack_error  = out_item_reg.ack_error;
    assign m_busy_res   = out_item_reg.busy_res;

endmodule

/* hw/rtl/i2cm_seq.sv */
// Bus sequencer: transaction state and the per-tick step logic.
module i2cm_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  i2cm_pkg::in_item_t  item,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::res_item_t result
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_HI, PH_ST_LO, PH_TX_SET, PH_TX_HI, PH_TX_LO, PH_AK_REL, PH_AK_HI,
        PH_AK_POLL, PH_TX_WAIT, PH_RX_LO, PH_RX_HI, PH_RA_SET, PH_RA_HI, PH_SP_LO, PH_SP_HI
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SLAW = 2'd0,
        KIND_SUB  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_SLAR = 2'd3
    } kind_t;

    localparam logic [1:0] ModeSend = 2'd1;
    localparam logic [1:0] ModeRecv = 2'd0;
    localparam logic [3:0] BitsPerByte = 4'd8;

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    logic [10:0] delay_count_reg, delay_count_next;
    logic [7:0]  ack_timer_reg, ack_timer_next;
    logic [1:0]  latched_mode_reg, latched_mode_next;
    logic [7:0]  latched_slave_reg, latched_slave_next;
    logic [7:0]  latched_sub_reg, latched_sub_next;
    logic        err_flag_reg, err_flag_next;

    logic [2:0]  phase_us;
    logic [10:0] phase_ticks;
    logic [10:0] ticks_raw;
    logic [11:0] delay_inc;
    logic [7:0]  shift_sampled;
    logic [3:0]  bit_inc;
    logic [8:0]  bytes_dec;
    logic        txbit;
    logic        ackbit;

    // Microseconds that each timed phase lasts; the untimed phases get zero.
    always_comb begin
        unique case (phase_reg)
            PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI:                    phase_us = 3'd4;
            PH_TX_SET, PH_TX_HI, PH_TX_LO, PH_RX_LO, PH_RA_SET, PH_RA_HI: phase_us = 3'd2;
            PH_AK_REL, PH_AK_HI, PH_RX_HI:                             phase_us = 3'd1;
            default:                                                   phase_us = 3'd0;
        endcase
    end

    // The scale factor is a power of two, so the product is masked shifts joined by OR.
    assign ticks_raw   = ({3'b0, cfg.ticks_per_us} & {11{phase_us[0]}})
                       | ({2'b0, cfg.ticks_per_us, 1'b0} & {11{phase_us[1]}})
                       | ({1'b0, cfg.ticks_per_us, 2'b0} & {11{phase_us[2]}});
    assign phase_ticks = (ticks_raw == 11'd0) ? 11'd1 : ticks_raw;

    assign delay_inc = {1'b0, delay_count_reg} + 12'd1;
    assign bit_inc   = bit_index_reg + 4'd1;
    assign bytes_dec = bytes_left_reg - 9'd1;
    assign txbit     = shift_byte_reg[7];
    assign ackbit    = (bytes_left_reg == 9'd0);

    // A read bit is sampled on the first tick of SCL high.
    assign shift_sampled = (phase_reg == PH_RX_HI && delay_count_reg == 11'd0)
                         ? {shift_byte_reg[6:0], item.sda_in} : shift_byte_reg;

    // Line levels and the next state for this tick.
    always_comb begin
        phase_next         = phase_reg;
        kind_next          = kind_reg;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        bytes_left_next    = bytes_left_reg;
        delay_count_next   = delay_count_reg;
        ack_timer_next     = ack_timer_reg;
        latched_mode_next  = latched_mode_reg;
        latched_slave_next = latched_slave_reg;
        latched_sub_next   = latched_sub_reg;
        err_flag_next      = err_flag_reg;

        result            = '0;
        result.scl_out    = 1'b1;
        result.sda_out    = 1'b1;
        result.sda_drive  = 1'b1;
        result.tx_request = (phase_reg == PH_TX_WAIT);
        result.busy_res   = (phase_reg != PH_IDLE);

        // Levels on the bus follow the phase at the start of the tick.
        unique case (phase_reg)
            PH_ST_LO: result.sda_out = 1'b0;
            PH_TX_SET, PH_TX_LO: begin
                result.scl_out = 1'b0;
                result.sda_out = txbit;
            end
            PH_TX_HI: result.sda_out = txbit;
            PH_AK_REL, PH_TX_WAIT, PH_RX_LO: begin
                result.scl_out   = 1'b0;
                result.sda_drive = 1'b0;
            end
            PH_AK_HI, PH_AK_POLL, PH_RX_HI: result.sda_drive = 1'b0;
            PH_RA_SET: begin
                result.scl_out = 1'b0;
                result.sda_out = ackbit;
            end
            PH_RA_HI: result.sda_out = ackbit;
            PH_SP_LO: begin
                result.scl_out = 1'b0;
                result.sda_out = 1'b0;
            end
            default: ;
        endcase

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.start_req) begin
                    latched_mode_next  = item.mode;
                    latched_slave_next = item.slave_addr;
                    latched_sub_next   = item.sub_addr;
                    bytes_left_next    = (item.byte_count == 8'd0) ? 9'd256
                                       : {1'b0, item.byte_count};
                    kind_next          = (item.mode == ModeRecv) ? KIND_SLAR : KIND_SLAW;
                    err_flag_next      = 1'b0;
                    phase_next         = PH_ST_HI;
                    delay_count_next   = '0;
                end
            end
            PH_TX_WAIT: begin
                if (item.tx_valid) begin
                    shift_byte_next  = item.tx_byte;
                    bit_index_next   = '0;
                    phase_next       = PH_TX_SET;
                    delay_count_next = '0;
                end
            end
            PH_AK_POLL: begin
                if (!item.sda_in) begin
                    // Acknowledge seen: move on by which byte was in flight.
                    delay_count_next = '0;
                    unique case (kind_reg)
                        KIND_SLAW: begin
                            kind_next       = KIND_SUB;
                            shift_byte_next = latched_sub_reg;
                            bit_index_next  = '0;
                            phase_next      = PH_TX_SET;
                        end
                        KIND_SUB: begin
                            if (latched_mode_reg == ModeSend) begin
                                kind_next  = KIND_DATA;
                                phase_next = PH_TX_WAIT;
                            end else begin
                                kind_next  = KIND_SLAR;
                                phase_next = PH_ST_HI;
                            end
                        end
                        KIND_DATA: begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 9'd0) begin
                                err_flag_next = 1'b0;
                                phase_next    = PH_SP_LO;
                            end else begin
                                phase_next = PH_TX_WAIT;
                            end
                        end
                        default: begin
                            bit_index_next  = '0;
                            shift_byte_next = '0;
                            phase_next      = PH_RX_LO;
                        end
                    endcase
                end else if (ack_timer_reg >= cfg.ack_wait_limit) begin
                    err_flag_next    = 1'b1;
                    phase_next       = PH_SP_LO;
                    delay_count_next = '0;
                end else begin
                    ack_timer_next = ack_timer_reg + 8'd1;
                end
            end
            default: begin
                shift_byte_next = shift_sampled;
                if (delay_inc < {1'b0, phase_ticks}) begin
                    delay_count_next = delay_inc[10:0];
                end else begin
                    // Timed phase over: pick the next phase.
                    delay_count_next = '0;
                    unique case (phase_reg)
                        PH_ST_HI: phase_next = PH_ST_LO;
                        PH_ST_LO: begin
                            shift_byte_next = (kind_reg == KIND_SLAR)
                                            ? {latched_slave_reg[7:1], 1'b1}
                                            : {latched_slave_reg[7:1], 1'b0};
                            bit_index_next  = '0;
                            phase_next      = PH_TX_SET;
                        end
                        PH_TX_SET: phase_next = PH_TX_HI;
                        PH_TX_HI:  phase_next = PH_TX_LO;
                        PH_TX_LO: begin
                            shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                            bit_index_next  = bit_inc;
                            if (bit_inc >= BitsPerByte) begin
                                ack_timer_next = '0;
                                phase_next     = PH_AK_REL;
                            end else begin
                                phase_next = PH_TX_SET;
                            end
                        end
                        PH_AK_REL: phase_next = PH_AK_HI;
                        PH_AK_HI:  phase_next = PH_AK_POLL;
                        PH_RX_LO:  phase_next = PH_RX_HI;
                        PH_RX_HI: begin
                            bit_index_next = bit_inc;
                            if (bit_inc >= BitsPerByte) begin
                                result.rx_valid = 1'b1;
                                result.rx_byte  = shift_sampled;
                                bytes_left_next = bytes_dec;
                                phase_next      = PH_RA_SET;
                            end else begin
                                phase_next = PH_RX_LO;
                            end
                        end
                        PH_RA_SET: phase_next = PH_RA_HI;
                        PH_RA_HI: begin
                            if (bytes_left_reg == 9'd0) begin
                                err_flag_next = 1'b0;
                                phase_next    = PH_SP_LO;
                            end else begin
                                bit_index_next  = '0;
                                shift_byte_next = '0;
                                phase_next      = PH_RX_LO;
                            end
                        end
                        PH_SP_LO: phase_next = PH_SP_HI;
                        PH_SP_HI: begin
                            result.done_res  = 1'b1;
                            result.ack_error = err_flag_reg;
                            err_flag_next    = 1'b0;
                            phase_next       = PH_IDLE;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Transaction state advances once per tick taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            kind_reg          <= KIND_SLAR;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            bytes_left_reg    <= '0;
            delay_count_reg   <= '0;
            ack_timer_reg     <= '0;
            latched_mode_reg  <= '0;
            latched_slave_reg <= '0;
            latched_sub_reg   <= '0;
            err_flag_reg      <= 1'b0;
        end else if (step) begin
            phase_reg         <= phase_next;
            kind_reg          <= kind_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            bytes_left_reg    <= bytes_left_next;
            delay_count_reg   <= delay_count_next;
            ack_timer_reg     <= ack_timer_next;
            latched_mode_reg  <= latched_mode_next;
            latched_slave_reg <= latched_slave_next;
            latched_sub_reg   <= latched_sub_next;
            err_flag_reg      <= err_flag_next;
        end
    end

endmodule

/* hw/rtl/i2cm_checker.sv */
// Port-level checks on the I2C transaction master and their binding.
module i2cm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_out,
    input logic       m_sda_out,
    input logic       m_sda_drive,
    input logic       m_tx_request,
    input logic       m_rx_valid,
    input logic [7:0] m_rx_byte,
    input logic       m_done_res,
    input logic       m_ack_error,
    input logic       m_busy_res
);

    // An error flag only comes with the end of a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_error |-> m_done_res)
        else $error("ack_error without done_res");

    // With no new byte, the received byte reads as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rx_valid |-> m_rx_byte == 8'd0)
        else $error("rx_byte not zero without rx_valid");

    // Waiting for write data holds SCL low with SDA released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_request |-> !m_scl_out && !m_sda_drive && m_busy_res)
        else $error("bus not parked while waiting for write data");

    // An idle bus has both lines driven high.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_out && m_sda_out && m_sda_drive && !m_done_res)
        else $error("idle bus not driven high");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_out) && $stable(m_sda_out)
            && $stable(m_rx_byte) && $stable(m_done_res))
        else $error("result beat changed while stalled");

endmodule

bind i2c_master_transaction i2cm_checker u_i2cm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scl_out    (m_scl_out),
    .m_sda_out    (m_sda_out),
    .m_sda_drive  (m_sda_drive),
    .m_tx_request (m_tx_request),
    .m_rx_valid   (m_rx_valid),
    .m_rx_byte    (m_rx_byte),
    .m_done_res   (m_done_res),
    .m_ack_error  (m_ack_error),
    .m_busy_res   (m_busy_res)
);
